// ----- rtl/wrmc_pkg.sv -----
package wrmc_pkg;

  localparam int PATTERN_CHARS = 16;
  localparam int COUNT_BITS    = 16;

  // word length saturates at PATTERN_CHARS + 1 ("too long")
  localparam int LEN_W = $clog2(PATTERN_CHARS + 2);
  localparam int IDX_W = (PATTERN_CHARS > 1) ? $clog2(PATTERN_CHARS) : 1;

  localparam int CHAR_W    = 8;
  localparam int PAT_CHARS = 16;      // storage of the two pattern registers
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 64;
  localparam int CFG_LEN_W = 5;
  localparam int OUT_CNT_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_PAT_LO = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_HI = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_LEN = 2'd2;

  localparam logic [CHAR_W-1:0] UPPER_A     = 8'd65;
  localparam logic [CHAR_W-1:0] UPPER_Z     = 8'd90;
  localparam logic [CHAR_W-1:0] CASE_OFFSET = 8'd32;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  typedef struct packed {
    logic is_delim;
    logic fwd_eq;
    logic rev_eq;
  } wrmc_char_t;

  function automatic logic [CHAR_W-1:0] fold_char(input logic [CHAR_W-1:0] c);
    if (c >= UPPER_A && c <= UPPER_Z) begin
      return c + CASE_OFFSET;
    end
    return c;
  endfunction

  function automatic logic is_delim_char(input logic [CHAR_W-1:0] c);
    logic d;
    case (c) inside
      8'h20, 8'h2D, 8'h2C, 8'h21, 8'h60, 8'h40, 8'h23, 8'h24, 8'h25,
      8'h5E, 8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h7C, 8'h3A,
      8'h3B, 8'h3E, 8'h3C, 8'h7E, 8'h2F, 8'h2E, 8'h5B, 8'h5D, 8'h22: d = 1'b1;
      default: d = 1'b0;
    endcase
    return d;
  endfunction

endpackage

// ----- rtl/wrmc_char_cmp.sv -----
module wrmc_char_cmp
  import wrmc_pkg::*;
(
  input  logic [CHAR_W-1:0]           char_code,
  input  logic [PAT_CHARS*CHAR_W-1:0] pattern,     // already case folded
  input  logic [IDX_W-1:0]            fwd_idx,
  input  logic [IDX_W-1:0]            rev_idx,
  output wrmc_char_t                  res
);

  logic [CHAR_W-1:0]        folded;
  logic [PATTERN_CHARS-1:0] eq_vec;

  assign folded = fold_char(char_code);

  // compare against every pattern position, then pick the two we need
  always_comb begin
    for (int k = 0; k < PATTERN_CHARS; k++) begin
      eq_vec[k] = (folded == pattern[k*CHAR_W +: CHAR_W]);
    end
  end

  assign res.is_delim = is_delim_char(char_code);
  assign res.fwd_eq   = eq_vec[fwd_idx];
  assign res.rev_eq   = eq_vec[rev_idx];

endmodule

// ----- rtl/word_and_reverse_match_counter.sv -----
// Whole-word match counter. Text bytes stream in one request per cycle while
// in_ready is high (in_mode = 0); A-Z fold to lower case and the 27
// punctuation/space delimiters split words. Each closed word equal to the
// pattern adds one, and one more if it equals the reversed pattern, so
// palindromes count twice. An end-of-line request (in_mode = 1) closes the
// last word and loads the saturating count into the output register, visible
// the cycle after it is accepted; the line state then clears. Every request
// is handled by the single update of the word flags and counter registers;
// in_ready drops only while a finished count waits on a stalled out_ready.
// Configuration writes are always accepted and must happen while idle.
module word_and_reverse_match_counter
  import wrmc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DAT_W-1:0]  cfg_data,

  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_mode,
  input  logic [CHAR_W-1:0]     in_char_code,

  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [OUT_CNT_W-1:0]  out_match_count,
  output logic                  out_count_saturated
);

  logic [PAT_CHARS*CHAR_W-1:0] pattern_r;
  logic [CFG_LEN_W-1:0]        pat_len_r;

  logic                  fwd_ok_r, fwd_ok_nxt;
  logic                  rev_ok_r, rev_ok_nxt;
  logic [LEN_W-1:0]      wlen_r, wlen_nxt;
  logic [COUNT_BITS-1:0] count_r, count_nxt;
  logic                  sat_r, sat_nxt;

  logic                  out_valid_r;
  logic [OUT_CNT_W-1:0]  out_cnt_r;
  logic                  out_sat_r;

  logic [LEN_W-1:0]      eff_len;
  logic [LEN_W-1:0]      rev_pos;
  logic                  in_fire;
  logic                  close_word;
  logic [1:0]            inc;
  logic [COUNT_BITS:0]   sum;
  logic [COUNT_BITS-1:0] count_closed;
  logic                  sat_closed;
  logic [31:0]           count_ext;
  wrmc_char_t            cmp;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;

  assign eff_len = (pat_len_r > CFG_LEN_W'(PATTERN_CHARS)) ? LEN_W'(PATTERN_CHARS)
                                                            : LEN_W'(pat_len_r);
  assign rev_pos = eff_len - LEN_W'(1) - wlen_r;

  wrmc_char_cmp u_cmp (
    .char_code (in_char_code),
    .pattern   (pattern_r),
    .fwd_idx   (wlen_r[IDX_W-1:0]),
    .rev_idx   (rev_pos[IDX_W-1:0]),
    .res       (cmp)
  );

  // closing a word adds up to two; an increment lost at the top sets sat
  assign inc = (wlen_r == eff_len) ? (2'(fwd_ok_r) + 2'(rev_ok_r)) : 2'd0;
  assign sum = {1'b0, count_r} + (COUNT_BITS+1)'(inc);
  always_comb begin
    if (sum > {1'b0, COUNT_MAX}) begin
      count_closed = COUNT_MAX;
      sat_closed   = 1'b1;
    end else begin
      count_closed = sum[COUNT_BITS-1:0];
      sat_closed   = sat_r;
    end
  end

  assign close_word = in_mode || cmp.is_delim;

  always_comb begin
    fwd_ok_nxt = fwd_ok_r;
    rev_ok_nxt = rev_ok_r;
    wlen_nxt   = wlen_r;
    count_nxt  = count_r;
    sat_nxt    = sat_r;
    if (in_fire) begin
      if (close_word) begin
        fwd_ok_nxt = 1'b1;
        rev_ok_nxt = 1'b1;
        wlen_nxt   = '0;
        if (in_mode) begin
          count_nxt = '0;
          sat_nxt   = 1'b0;
        end else begin
          count_nxt = count_closed;
          sat_nxt   = sat_closed;
        end
      end else begin
        if (wlen_r < eff_len) begin
          fwd_ok_nxt = fwd_ok_r && cmp.fwd_eq;
          rev_ok_nxt = rev_ok_r && cmp.rev_eq;
        end else begin
          fwd_ok_nxt = 1'b0;
          rev_ok_nxt = 1'b0;
        end
        if (wlen_r <= LEN_W'(PATTERN_CHARS)) begin
          wlen_nxt = wlen_r + LEN_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r <= '0;
      pat_len_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_PAT_LO: begin
          for (int k = 0; k < 8; k++) begin
            pattern_r[k*CHAR_W +: CHAR_W] <= fold_char(cfg_data[k*CHAR_W +: CHAR_W]);
          end
        end
        CFG_PAT_HI: begin
          for (int k = 0; k < 8; k++) begin
            pattern_r[(k+8)*CHAR_W +: CHAR_W] <= fold_char(cfg_data[k*CHAR_W +: CHAR_W]);
          end
        end
        CFG_PAT_LEN: pat_len_r <= cfg_data[CFG_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_ok_r    <= 1'b1;
      rev_ok_r    <= 1'b1;
      wlen_r      <= '0;
      count_r     <= '0;
      sat_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      fwd_ok_r <= fwd_ok_nxt;
      rev_ok_r <= rev_ok_nxt;
      wlen_r   <= wlen_nxt;
      count_r  <= count_nxt;
      sat_r    <= sat_nxt;
      if (in_fire && in_mode) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign count_ext = 32'(count_closed);

  always_ff @(posedge clk) begin
    if (in_fire && in_mode) begin
      out_cnt_r <= count_ext[OUT_CNT_W-1:0];
      out_sat_r <= sat_closed;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_match_count     = out_cnt_r;
  assign out_count_saturated = out_sat_r;

endmodule

// ----- rtl/wrmc_checker.sv -----
module wrmc_checker
  import wrmc_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 in_mode,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [OUT_CNT_W-1:0] out_match_count,
  input logic                 out_count_saturated
);

  logic [31:0] max_ext;
  assign max_ext = 32'(COUNT_MAX);

  // an end-of-line request always produces a result on the next cycle
  a_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_mode |=> out_valid)
    else $error("end-of-line request produced no result");

  // input only stalls behind a waiting result
  a_stall_reason: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled with no pending result");

  // saturated result must carry the maximum count
  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_count_saturated |-> out_match_count == max_ext[OUT_CNT_W-1:0])
    else $error("saturated flag with count below maximum");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_match_count)
                                && $stable(out_count_saturated))
    else $error("stalled result changed");

endmodule

bind word_and_reverse_match_counter wrmc_checker u_wrmc_checker (.*);
